>>> rtl/pfsc_pkg.sv
// shared types and constants for the prefix-free set checker
package pfsc_pkg;

   // default sizing
   localparam int NODE_COUNT_DEF = 4096;
   localparam int ALPHABET_DEF   = 10;

   // fixed field widths
   localparam int LETTER_W  = 4;
   localparam int STATUS_W  = 3;
   localparam int WORD_NO_W = 16;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_TAKEN     = 3'd0,
      ST_ACCEPTED  = 3'd1,
      ST_CONFLICT  = 3'd2,
      ST_POOL_FULL = 3'd3,
      ST_IGNORED   = 3'd4
   } status_type;

   // control sequencer states
   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK
   } state_type;

endpackage

>>> rtl/pfsc_ram.sv
// generic single-clock ram, one write and one registered read port
module pfsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, returns old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/prefix_free_set_checker.sv
// Prefix-free set checker: letters arrive one per transfer, each word is
// inserted into a prefix tree kept in one RAM of NODE_COUNT*ALPHABET child
// slots; every input transfer gives one result transfer. A letter is handled
// as a read of the child slot of the current node, then a decision with
// write-back; the single RAM port pair sets this split, and a stalled result
// holds the decision. Each slot holds the child pointer and the child's leaf
// bit; when a node other than the root gets a new child the slot pointing to
// it is rewritten in the following idle cycle, with forwarding to a read of
// the same slot. After reset the block clears all NODE_COUNT*ALPHABET slots
// (40960 at the defaults) and holds req_stall high meanwhile. Once a conflict
// or pool exhaustion is found, set_bad stays high and later letters are ignored.
module prefix_free_set_checker #(
   parameter int NODE_COUNT = pfsc_pkg::NODE_COUNT_DEF,
   parameter int ALPHABET   = pfsc_pkg::ALPHABET_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [pfsc_pkg::LETTER_W-1:0]  req_letter,
   input  logic                           req_word_end,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [pfsc_pkg::STATUS_W-1:0]  rsp_status,
   output logic [pfsc_pkg::WORD_NO_W-1:0] rsp_word_number,
   output logic                           rsp_set_bad
);

   import pfsc_pkg::*;

   localparam int NODE_W      = $clog2(NODE_COUNT);
   localparam int CNT_W       = NODE_W + 1;
   localparam int ENTRY_W     = NODE_W + 1;
   localparam int TABLE_DEPTH = NODE_COUNT * ALPHABET;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);

   // sequencer
   state_type state_ff, state_in;
   logic      finish;
   logic      clear_done;
   logic      accept;

   // tree state
   logic [ADDR_W-1:0]    clear_addr_ff, clear_addr_in;
   logic [CNT_W-1:0]     nodes_used_ff, nodes_used_in;
   logic [NODE_W-1:0]    current_node_ff, current_node_in;
   logic                 path_old_ff, path_old_in;
   logic [WORD_NO_W-1:0] word_counter_ff, word_counter_in;
   logic                 bad_ff, bad_in;
   logic [ADDR_W-1:0]    prev_slot_ff, prev_slot_in;

   // item in flight
   logic [LETTER_W-1:0] letter_ff, letter_in;
   logic                word_end_ff, word_end_in;
   logic [ADDR_W-1:0]   slot_ff, slot_in;
   logic                fwd_hit_ff, fwd_hit_in;
   logic [ENTRY_W-1:0]  fwd_data_ff, fwd_data_in;

   // deferred leaf-bit clear of the parent slot
   logic                pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic [ENTRY_W-1:0]  pend_data_ff, pend_data_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [WORD_NO_W-1:0] rsp_word_number_ff, rsp_word_number_in;
   logic                 rsp_set_bad_ff, rsp_set_bad_in;

   // ram ports
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   // lookup decode
   logic [ADDR_W-1:0]  slot_addr;
   logic [ENTRY_W-1:0] entry;
   logic [NODE_W-1:0]  child_ptr;
   logic               child_leaf;
   logic               ignored;
   logic               need_new;
   logic               pool_full;
   logic               alloc;

   // child slot address of the incoming letter
   assign slot_addr = ADDR_W'(current_node_ff) * ADDR_W'(ALPHABET) + ADDR_W'(req_letter);

   assign clear_done = (clear_addr_ff == ADDR_W'(TABLE_DEPTH - 1));
   assign finish     = (state_ff == S_LOOK) && (!rsp_valid_ff || !rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_LOOK;
         end
         S_LOOK: begin
            if (finish) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      case (state_ff)
         S_CLEAR: req_stall = 1'b1;
         S_IDLE:  req_stall = 1'b0;
         S_LOOK:  req_stall = 1'b1;
         default: req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   // slot entry, forwarded when the pending rewrite hit the same slot
   assign entry      = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
   assign child_ptr  = entry[NODE_W-1:0];
   assign child_leaf = entry[NODE_W];
   assign ignored    = bad_ff || (32'(letter_ff) >= 32'(ALPHABET));
   assign need_new   = (child_ptr == '0);
   assign pool_full  = (nodes_used_ff >= CNT_W'(NODE_COUNT));
   assign alloc      = finish && !ignored && need_new && !pool_full;

   // capture of an accepted letter
   always_comb begin
      letter_in   = letter_ff;
      word_end_in = word_end_ff;
      slot_in     = slot_ff;
      fwd_hit_in  = fwd_hit_ff;
      fwd_data_in = fwd_data_ff;
      if (accept) begin
         letter_in   = req_letter;
         word_end_in = req_word_end;
         slot_in     = slot_addr;
         fwd_hit_in  = pend_valid_ff && (slot_addr == pend_addr_ff);
         fwd_data_in = pend_data_ff;
      end
   end

   // tree update and result
   always_comb begin
      nodes_used_in      = nodes_used_ff;
      current_node_in    = current_node_ff;
      path_old_in        = path_old_ff;
      word_counter_in    = word_counter_ff;
      bad_in             = bad_ff;
      prev_slot_in       = prev_slot_ff;
      rsp_status_in      = rsp_status_ff;
      rsp_word_number_in = rsp_word_number_ff;
      rsp_set_bad_in     = rsp_set_bad_ff;
      if (finish) begin
         rsp_word_number_in = word_counter_ff;
         if (ignored) begin
            rsp_status_in = ST_IGNORED;
         end else if (need_new && pool_full) begin
            rsp_status_in = ST_POOL_FULL;
            bad_in        = 1'b1;
         end else if (!need_new && path_old_ff && child_leaf) begin
            // walked onto a node where an earlier word ended
            rsp_status_in = ST_CONFLICT;
            bad_in        = 1'b1;
         end else if (!word_end_ff) begin
            rsp_status_in   = ST_TAKEN;
            current_node_in = need_new ? nodes_used_ff[NODE_W-1:0] : child_ptr;
            prev_slot_in    = slot_ff;
            if (need_new) begin
               nodes_used_in = nodes_used_ff + CNT_W'(1);
               path_old_in   = 1'b0;
            end
         end else if (!need_new && path_old_ff) begin
            // word ends on an existing path
            rsp_status_in = ST_CONFLICT;
            bad_in        = 1'b1;
         end else begin
            rsp_status_in   = ST_ACCEPTED;
            current_node_in = '0;
            path_old_in     = 1'b1;
            if (need_new) nodes_used_in = nodes_used_ff + CNT_W'(1);
            if (word_counter_ff != '1) word_counter_in = word_counter_ff + WORD_NO_W'(1);
         end
         rsp_set_bad_in = bad_in;
      end
   end

   // parent slot loses its leaf bit when the current node gets a child
   always_comb begin
      pend_valid_in = 1'b0;
      pend_addr_in  = pend_addr_ff;
      pend_data_in  = pend_data_ff;
      if (alloc && (current_node_ff != '0)) begin
         pend_valid_in = 1'b1;
         pend_addr_in  = prev_slot_ff;
         pend_data_in  = {1'b0, current_node_ff};
      end
   end

   // result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish) rsp_valid_in = 1'b1;
   end

   // clearing pass address
   always_comb begin
      clear_addr_in = clear_addr_ff;
      if ((state_ff == S_CLEAR) && !clear_done) clear_addr_in = clear_addr_ff + ADDR_W'(1);
   end

   // ram port selection
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = pend_addr_ff;
      ram_wr_data = pend_data_ff;
      if (state_ff == S_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_addr_ff;
         ram_wr_data = '0;
      end else if (alloc) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = slot_ff;
         ram_wr_data = {1'b1, nodes_used_ff[NODE_W-1:0]};
      end else if (pend_valid_ff) begin
         ram_wr_en   = 1'b1;
      end
      ram_rd_addr = (state_ff == S_LOOK) ? slot_ff : slot_addr;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clear_addr_ff   <= '0;
         nodes_used_ff   <= CNT_W'(1);
         current_node_ff <= '0;
         path_old_ff     <= 1'b1;
         word_counter_ff <= '0;
         bad_ff          <= 1'b0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clear_addr_ff   <= clear_addr_in;
         nodes_used_ff   <= nodes_used_in;
         current_node_ff <= current_node_in;
         path_old_ff     <= path_old_in;
         word_counter_ff <= word_counter_in;
         bad_ff          <= bad_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prev_slot_ff       <= prev_slot_in;
      letter_ff          <= letter_in;
      word_end_ff        <= word_end_in;
      slot_ff            <= slot_in;
      fwd_hit_ff         <= fwd_hit_in;
      fwd_data_ff        <= fwd_data_in;
      pend_addr_ff       <= pend_addr_in;
      pend_data_ff       <= pend_data_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_word_number_ff <= rsp_word_number_in;
      rsp_set_bad_ff     <= rsp_set_bad_in;
   end

   // child slot table with folded leaf bits
   pfsc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_child_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_word_number = rsp_word_number_ff;
   assign rsp_set_bad     = rsp_set_bad_ff;

`ifndef ASSERT_OFF
   // a deferred parent rewrite is flushed in the very next cycle
   a_pend_one_cycle: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |=> !pend_valid_ff)
      else $error("pending slot rewrite held longer than one cycle");

   // the deferred rewrite never collides with a lookup write-back
   a_pend_not_in_look: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == S_IDLE))
      else $error("pending slot rewrite outside idle");

   // the bad flag is sticky
   a_bad_sticky: assert property (@(posedge clock) disable iff (reset)
      bad_ff |=> bad_ff)
      else $error("bad flag cleared");

   // node allocation never passes the pool size
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      nodes_used_ff <= CNT_W'(NODE_COUNT))
      else $error("node count beyond pool");
`endif

endmodule
